// File: rtl/mft_pkg.sv
// shared types and constants for the manchester frame transmitter
package mft_pkg;

    // request codes carried in tuser
    typedef enum logic [2:0] {
        REQ_LOAD  = 3'd0,
        REQ_START = 3'd1,
        REQ_MID   = 3'd2,
        REQ_END   = 3'd3,
        REQ_BLOCK = 3'd4,
        REQ_ALLOW = 3'd5,
        REQ_RETX  = 3'd6
    } req_t;

    localparam logic [7:0] PREAMBLE_RESET = 8'h55;
    localparam logic [2:0] TOP_BIT        = 3'd7;

    // classified request handed from front to back
    typedef struct packed {
        req_t       req;
        logic       idx_ok;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
        logic [7:0] frame_length;
        logic       receiver_idle;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic send_enabled;
        logic resend_pending;
        logic sending;
        logic accepted;
        logic line_level;
    } result_t;

endpackage

// File: rtl/manchester_frame_transmitter_top.sv
// top level of the manchester frame transmitter
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tuser: req_type; tdata: index, byte, length, rx idle
//  m_        out  m_tvalid/m_tready  tdata: line, accepted, sending, pending, enabled
//  cfg_      in   cfg_wr_en          cfg_wr_data: preamble byte
//
// one request per cycle sustained while m_tready is high; each result passes through
// the queue stage, then execution into the result register
// every request does at most one payload store read, prefetched at the next byte position
// aresetn is synchronous; it empties the queue and returns the line to idle high
// a stalled result register holds the back end; the queue then fills and drops s_tready
module manchester_frame_transmitter_top import mft_pkg::*; #(
    parameter int MAX_PAYLOAD = 255,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] payload_index, [15:8] payload_byte, [23:16] frame_length, [24] receiver_idle
    input  logic [31:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] line_level, [1] accepted, [2] sending, [3] resend_pending, [4] send_enabled
    output logic [7:0]  m_tdata
);

    logic q_valid, q_pop;
    cmd_t q_cmd;

    mft_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    mft_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// File: rtl/mft_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module mft_front import mft_pkg::*; #(
    parameter int MAX_PAYLOAD = 255,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    cmd_t            cmd_in;
    logic            push;

    // classify the incoming transfer
    always_comb begin
        cmd_in.req           = req_t'(s_tuser);
        cmd_in.payload_index = s_tdata[7:0];
        cmd_in.payload_byte  = s_tdata[15:8];
        cmd_in.frame_length  = s_tdata[23:16];
        cmd_in.receiver_idle = s_tdata[24];
        cmd_in.idx_ok        = ({1'b0, s_tdata[7:0]} < 9'(MAX_PAYLOAD));
    end

    assign s_tready = (count_reg != CW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/mft_back.sv
// back end: frame state, payload store, manchester line and result register
module mft_back import mft_pkg::*; #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]    mem [MAX_PAYLOAD];
    logic [7:0]    rd_data_reg;

    logic [7:0]    preamble_reg;
    logic [7:0]    frame_pre_reg, frame_pre_next;
    logic [7:0]    len_reg, len_next;
    logic [12:0]   ev_reg, ev_next;
    logic [8:0]    pos_reg, pos_next;
    logic [2:0]    bit_reg, bit_next;
    logic          en_reg, en_next;
    logic          pend_reg, pend_next;
    logic          line_reg, line_next;
    logic          m_valid_reg;
    result_t       m_data_reg;

    logic          fire, acc, mem_we, tx_bit;
    logic [7:0]    cur_byte;
    logic [8:0]    rd_pos;
    logic          rd_ok_now, rd_ok_next;
    logic [7:0]    arm_len;
    logic          arm;
    result_t       res;

    assign fire  = q_valid && (!m_valid_reg || m_tready);
    assign q_pop = fire;

    // byte under the bit pointer
    assign rd_ok_now = (pos_reg >= 9'd2) && ({1'b0, pos_reg} < 10'(MAX_PAYLOAD + 2));
    always_comb begin
        if (pos_reg == 9'd0) begin
            cur_byte = frame_pre_reg;
        end else if (pos_reg == 9'd1) begin
            cur_byte = len_reg;
        end else if (rd_ok_now) begin
            cur_byte = rd_data_reg;
        end else begin
            cur_byte = 8'h00;
        end
    end
    assign tx_bit = cur_byte[bit_reg];

    // request execution
    always_comb begin
        frame_pre_next = frame_pre_reg;
        len_next       = len_reg;
        ev_next        = ev_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        en_next        = en_reg;
        pend_next      = pend_reg;
        line_next      = line_reg;
        acc            = 1'b0;
        mem_we         = 1'b0;
        arm            = 1'b0;
        arm_len        = len_reg;
        if (fire) begin
            unique case (q_cmd.req) inside
                REQ_LOAD: begin
                    if (ev_reg == '0 && q_cmd.idx_ok) begin
                        mem_we = 1'b1;
                        acc    = 1'b1;
                    end
                end
                REQ_START: begin
                    if (ev_reg == '0 && en_reg && q_cmd.receiver_idle) begin
                        frame_pre_next = preamble_reg;
                        len_next       = q_cmd.frame_length;
                        arm_len        = q_cmd.frame_length;
                        arm            = 1'b1;
                        acc            = 1'b1;
                    end
                end
                REQ_MID, REQ_END: begin
                    if (ev_reg > 13'd1) begin
                        if (q_cmd.req == REQ_MID) begin
                            line_next = ~tx_bit;
                        end else begin
                            line_next = tx_bit;
                            if (bit_reg == '0) begin
                                bit_next = TOP_BIT;
                                pos_next = pos_reg + 1'b1;
                            end else begin
                                bit_next = bit_reg - 1'b1;
                            end
                        end
                        ev_next = ev_reg - 1'b1;
                    end else if (ev_reg == 13'd1) begin
                        line_next = 1'b1;
                        ev_next   = '0;
                    end
                end
                REQ_BLOCK: begin
                    if (ev_reg != '0) begin
                        pend_next = 1'b1;
                    end
                    en_next   = 1'b0;
                    ev_next   = '0;
                    line_next = 1'b1;
                end
                REQ_ALLOW: begin
                    en_next = 1'b1;
                end
                REQ_RETX: begin
                    if (pend_reg) begin
                        arm       = 1'b1;
                        pend_next = 1'b0;
                        acc       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // arm: (length + 2) * 16 + 1 half-bit events
        if (arm) begin
            pos_next = '0;
            bit_next = TOP_BIT;
            ev_next  = {{1'b0, arm_len} + 9'd2, 4'b0001};
        end
    end

    always_comb begin
        res.line_level     = line_next;
        res.accepted       = acc;
        res.sending        = (ev_next != '0);
        res.resend_pending = pend_next;
        res.send_enabled   = en_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg  <= PREAMBLE_RESET;
            frame_pre_reg <= PREAMBLE_RESET;
            len_reg       <= '0;
            ev_reg        <= '0;
            pos_reg       <= '0;
            bit_reg       <= TOP_BIT;
            en_reg        <= 1'b1;
            pend_reg      <= 1'b0;
            line_reg      <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                preamble_reg <= cfg_wr_data;
            end
            frame_pre_reg <= frame_pre_next;
            len_reg       <= len_next;
            ev_reg        <= ev_next;
            pos_reg       <= pos_next;
            bit_reg       <= bit_next;
            en_reg        <= en_next;
            pend_reg      <= pend_next;
            line_reg      <= line_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= res;
        end
    end

    // payload store, read ahead at the next byte position
    assign rd_pos     = pos_next - 9'd2;
    assign rd_ok_next = (pos_next >= 9'd2) && ({1'b0, pos_next} < 10'(MAX_PAYLOAD + 2));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_cmd.payload_index[AW-1:0]] <= q_cmd.payload_byte;
        end
        if (rd_ok_next) begin
            rd_data_reg <= mem[rd_pos[AW-1:0]];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg};

endmodule

// File: rtl/mft_checker.sv
// port-level checks for the manchester frame transmitter
module mft_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result side
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // reset leaves the request side ready
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("request side not ready after reset");

    // no frame in flight means the line sits idle high
    a_idle_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[0])
        else $error("line low while not sending");

    // padding bits above the result fields stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:5] == 3'b000)
        else $error("result padding not zero");

endmodule

bind manchester_frame_transmitter_top mft_checker u_mft_checker (.*);
